FILE: rtl/page_region_splitting_allocator_top_assert.svh
// Assertion macros for the page region allocator.
// Used by page_region_splitting_allocator_top; no other dependencies.
`ifndef PAGE_REGION_SPLITTING_ALLOCATOR_TOP_ASSERT_SVH
`define PAGE_REGION_SPLITTING_ALLOCATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define PRA_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PRA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define PRA_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define PRA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/pra_pkg.sv
// Shared types and codes for the page region allocator.
// No dependencies.
`default_nettype none
package pra_pkg;
  localparam logic [1:0] FUNC_APPEND = 2'd0;
  localparam logic [1:0] FUNC_PLACE  = 2'd1;
  localparam logic [1:0] FUNC_TOP    = 2'd2;
  localparam logic [1:0] FUNC_READ   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_NOROOM   = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam logic [3:0] TYPE_FREE = 4'd2;
  localparam logic [3:0] TYPE_MAX  = 4'd8;

  // configuration register indexes
  localparam logic CFG_LOW_PAGE  = 1'b0;
  localparam logic CFG_HIGH_PAGE = 1'b1;

  // datapath commands
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1; // latch request, reset scan index
  localparam logic [2:0] CMD_SCAN  = 3'd2; // read entry at scan index
  localparam logic [2:0] CMD_EVAL  = 3'd3; // evaluate read entry
  localparam logic [2:0] CMD_SHIFT = 3'd4; // move one entry up
  localparam logic [2:0] CMD_WRITE = 3'd5; // write one split piece
  localparam logic [2:0] CMD_FIN   = 3'd6; // load result register

  typedef struct packed {
    logic [2:0] op;
  } pra_cmd_t;

  typedef struct packed {
    logic scan_end;   // scan index reached used count
    logic hit;        // evaluated entry matches
    logic stop;       // evaluated entry ends the search
    logic shift_done; // gap is open
    logic write_done; // all pieces written
    logic direct;     // request finishes without a table scan
  } pra_stat_t;
endpackage
`default_nettype wire

FILE: rtl/pra_ram.sv
// Generic RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none
module pra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: rtl/pra_ctrl.sv
// Controller state machine for the page region allocator.
// Depends on pra_pkg.
`default_nettype none
module pra_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire pra_pkg::pra_stat_t stat,
  output pra_pkg::pra_cmd_t       cmd
);
  import pra_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;
  localparam logic [2:0] S_WAIT  = 3'd6; // wait for the registered table read

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = CMD_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.op    = CMD_START;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // direct requests and exhausted scans finish
        if (stat.direct || stat.scan_end) begin
          state_nxt = S_FIN;
        end else begin
          cmd.op    = CMD_SCAN;
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: state_nxt = S_EVAL;
      S_EVAL: begin
        cmd.op = CMD_EVAL;
        if (stat.hit)       state_nxt = S_SHIFT;
        else if (stat.stop) state_nxt = S_FIN;
        else                state_nxt = S_SCAN;
      end
      S_SHIFT: begin
        if (stat.shift_done) begin
          state_nxt = S_WRITE;
        end else begin
          cmd.op = CMD_SHIFT;
        end
      end
      S_WRITE: begin
        if (stat.write_done) begin
          state_nxt = S_FIN;
        end else begin
          cmd.op = CMD_WRITE;
        end
      end
      S_FIN: begin
        cmd.op        = CMD_FIN;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/pra_dp.sv
// Datapath of the page region allocator: region table, scan and split logic.
// Depends on pra_pkg and pra_ram.
`default_nettype none
module pra_dp #(
  parameter int TABLE_DEPTH      = 32,
  parameter int PAGE_NUMBER_BITS = 20
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire pra_pkg::pra_cmd_t           cmd,
  output pra_pkg::pra_stat_t               stat,
  input  wire logic [1:0]                  in_func,
  input  wire logic [PAGE_NUMBER_BITS-1:0] in_base_page,
  input  wire logic [PAGE_NUMBER_BITS:0]   in_page_count,
  input  wire logic [3:0]                  in_mem_type,
  input  wire logic [$clog2(TABLE_DEPTH)-1:0] in_entry_index,
  input  wire logic [PAGE_NUMBER_BITS-1:0] low_page,
  input  wire logic [PAGE_NUMBER_BITS:0]   high_page,
  output logic [1:0]                       out_status,
  output logic [PAGE_NUMBER_BITS-1:0]      out_result_page,
  output logic [PAGE_NUMBER_BITS-1:0]      out_entry_base,
  output logic [PAGE_NUMBER_BITS:0]        out_entry_count,
  output logic [3:0]                       out_entry_type,
  output logic                             out_entry_valid,
  output logic [$clog2(TABLE_DEPTH+1)-1:0] out_entries_in_use
);
  import pra_pkg::*;

  localparam int PB = PAGE_NUMBER_BITS;
  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int UW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = PB + PB + 1 + 4; // base, count, type
  localparam logic [UW-1:0] DEPTH_U = UW'(TABLE_DEPTH);

  // request registers
  logic [1:0]    func_r;
  logic [PB-1:0] b_r;
  logic [PB:0]   c_r;
  logic [3:0]    t_r;
  logic [IW-1:0] idx_r;
  logic          bad_r;
  logic [PB+1:0] lim_lo_r;
  logic [PB+1:0] lim_hi_r;

  logic [UW-1:0] used_r;
  logic [UW:0]   scan_r;         // scan / shift index
  logic [UW-1:0] hit_r;          // matching entry
  logic [PB+1:0] eb_r, ec_r;     // matched entry base and count
  logic [PB+1:0] pb_r;           // allocated start
  logic [1:0]    pieces_r;       // extra entries needed
  logic [1:0]    wcnt_r;         // pieces written
  logic [1:0]    st_r;
  logic          found_r;
  logic          sh_rd_r;

  // result registers
  logic [1:0]    o_st_r;
  logic [PB-1:0] o_rp_r, o_eb_r;
  logic [PB:0]   o_ec_r;
  logic [3:0]    o_et_r;
  logic          o_ev_r;

  // RAM
  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;

  pra_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_tbl (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [PB-1:0] r_base;
  logic [PB:0]   r_cnt;
  logic [3:0]    r_type;
  assign r_base = rdata[EW-1 -: PB];
  assign r_cnt  = rdata[EW-1-PB -: PB+1];
  assign r_type = rdata[3:0];

  // evaluation of the read entry
  logic [PB+1:0] e_b, e_e, req_e, top_s;
  logic          place_m, top_pass, top_fit;
  assign e_b   = (PB+2)'(r_base);
  assign e_e   = e_b + (PB+2)'(r_cnt);
  assign req_e = (PB+2)'(b_r) + (PB+2)'(c_r);
  assign top_s = e_e - (PB+2)'(c_r);
  assign place_m  = (r_type == TYPE_FREE) && ((PB+2)'(b_r) >= e_b) && (req_e <= e_e);
  assign top_pass = (r_type == TYPE_FREE) && !((e_b < lim_lo_r) && (e_e <= lim_lo_r));
  assign top_fit  = (e_b < lim_hi_r) && ((PB+2)'(r_cnt) >= (PB+2)'(c_r));

  // split shape of the found entry
  logic [PB+1:0] off, tail;
  assign off  = pb_r - eb_r;
  assign tail = ec_r - off - (PB+2)'(c_r);

  // shift: read k-1 then write at k-1+pieces
  logic [UW:0] dst;
  assign dst = scan_r - 1'b1 + (UW+1)'(pieces_r);

  // end of the last entry, read from the table at start
  logic [PB+1:0] app_end;
  assign app_end = (used_r == '0) ? '0 : e_e;

  // piece being written
  logic [PB+1:0] w_b, w_c;
  logic [3:0]    w_t;
  logic [UW:0]   w_a;
  always_comb begin
    w_a = (UW+1)'(hit_r) + (UW+1)'(wcnt_r);
    w_b = pb_r; w_c = (PB+2)'(c_r); w_t = t_r;
    if (pieces_r == 2'd0) begin
      w_b = eb_r; w_c = ec_r;
    end else if (off == '0) begin
      if (wcnt_r == 2'd1) begin
        w_b = pb_r + (PB+2)'(c_r); w_c = tail; w_t = TYPE_FREE;
      end
    end else begin
      if (wcnt_r == 2'd0) begin
        w_b = eb_r; w_c = off; w_t = TYPE_FREE;
      end else if (wcnt_r == 2'd2) begin
        w_b = pb_r + (PB+2)'(c_r); w_c = tail; w_t = TYPE_FREE;
      end
    end
  end

  // pieces needed by the entry under evaluation
  logic [1:0]    pieces_nx;
  logic [PB+1:0] x_s, x_off, x_tail;
  always_comb begin
    x_s = (func_r == FUNC_PLACE) ? (PB+2)'(b_r) : top_s;
    if (func_r == FUNC_PLACE) begin
      x_off  = (PB+2)'(b_r) - e_b;
      x_tail = e_e - req_e;
    end else begin
      // top allocation always ends at the end of the entry
      x_off  = (PB+2)'(r_cnt) - (PB+2)'(c_r);
      x_tail = '0;
    end
    pieces_nx = 2'((x_off != '0) ? 1 : 0) + 2'((x_tail != '0) ? 1 : 0);
  end

  // append check, needed before the write in FIN
  logic [1:0] st_app;
  always_comb begin
    st_app = ST_OK;
    if (bad_r || ((PB+2)'(b_r) < app_end) || (req_e > (PB+2)'(1) << PB)) st_app = ST_INVALID;
    else if (used_r >= DEPTH_U) st_app = ST_NOROOM;
  end

  // RAM ports
  always_comb begin
    we    = 1'b0;
    waddr = IW'(w_a);
    wdata = {w_b[PB-1:0], w_c[PB:0], w_t};
    // read and append keep their entry on the read port until FIN
    if (func_r == FUNC_READ)        raddr = idx_r;
    else if (func_r == FUNC_APPEND) raddr = IW'(used_r - 1'b1);
    else                            raddr = IW'(scan_r);
    if (cmd.op == CMD_START) begin
      raddr = (in_func == FUNC_READ) ? in_entry_index : IW'(used_r - 1'b1);
    end
    if (cmd.op == CMD_SHIFT) begin
      raddr = IW'(scan_r - 1'b1);
      waddr = IW'(dst);
      wdata = rdata;
      we    = sh_rd_r;
    end
    if (cmd.op == CMD_WRITE) we = 1'b1;
    if (cmd.op == CMD_FIN && func_r == FUNC_APPEND && st_app == ST_OK) begin
      we    = 1'b1;
      waddr = IW'(used_r);
      wdata = {b_r, c_r, t_r};
    end
  end

  // status to controller
  always_comb begin
    stat.scan_end   = (scan_r >= (UW+1)'(used_r));
    stat.hit        = 1'b0;
    stat.stop       = 1'b0;
    if (func_r == FUNC_PLACE) begin
      stat.hit = place_m && (used_r + UW'(pieces_nx) <= DEPTH_U);
      stat.stop = place_m;
    end else begin
      stat.hit  = top_pass && top_fit && (used_r + UW'(pieces_nx) <= DEPTH_U);
      stat.stop = top_pass;
    end
    stat.shift_done = (scan_r <= (UW+1)'(hit_r) + 1'b1) && !sh_rd_r;
    stat.write_done = (wcnt_r > pieces_r);
    stat.direct     = (func_r == FUNC_APPEND) || (func_r == FUNC_READ) || bad_r;
  end

  // result of the finished request
  logic [1:0]    o_st_nxt;
  logic [PB-1:0] o_rp_nxt, o_eb_nxt;
  logic [PB:0]   o_ec_nxt;
  logic [3:0]    o_et_nxt;
  logic          o_ev_nxt;
  logic [UW-1:0] used_nxt;
  always_comb begin
    o_st_nxt = ST_OK; o_rp_nxt = '0; o_eb_nxt = '0; o_ec_nxt = '0;
    o_et_nxt = '0; o_ev_nxt = 1'b0;
    used_nxt = used_r;
    if (func_r == FUNC_APPEND) begin
      o_st_nxt = st_app;
      if (st_app == ST_OK) used_nxt = used_r + 1'b1;
    end else if (func_r == FUNC_READ) begin
      if (UW'(idx_r) < used_r) begin
        o_eb_nxt = r_base; o_ec_nxt = r_cnt; o_et_nxt = r_type; o_ev_nxt = 1'b1;
      end else begin
        o_st_nxt = ST_INVALID;
      end
    end else if (bad_r) begin
      o_st_nxt = ST_INVALID;
    end else begin
      o_st_nxt = st_r;
      if (found_r) begin
        o_rp_nxt = pb_r[PB-1:0];
        used_nxt = used_r + UW'(pieces_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r     <= '0;
      sh_rd_r    <= 1'b0;
    end else begin
      unique case (cmd.op)
        CMD_START: begin
          func_r   <= in_func;
          b_r      <= in_base_page;
          c_r      <= in_page_count;
          t_r      <= in_mem_type;
          idx_r    <= in_entry_index;
          bad_r    <= (in_page_count == '0) || (in_mem_type > TYPE_MAX);
          lim_lo_r <= (PB+2)'(low_page);
          lim_hi_r <= (PB+2)'(high_page);
          scan_r   <= '0;
          found_r  <= 1'b0;
          st_r     <= ST_NOTFOUND;
          wcnt_r   <= '0;
          sh_rd_r  <= 1'b0;
        end
        CMD_SCAN: ;
        CMD_EVAL: begin
          if (stat.stop) begin
            if (func_r == FUNC_PLACE || top_fit) begin
              st_r <= (used_r + UW'(pieces_nx) <= DEPTH_U) ? ST_OK : ST_NOROOM;
            end
          end
          if (stat.hit) begin
            found_r  <= 1'b1;
            hit_r    <= UW'(scan_r);
            eb_r     <= e_b;
            ec_r     <= (PB+2)'(r_cnt);
            pb_r     <= x_s;
            pieces_r <= pieces_nx;
            scan_r   <= (UW+1)'(used_r);
          end else begin
            scan_r <= scan_r + 1'b1;
          end
        end
        CMD_SHIFT: begin
          // alternate read and write of one entry
          sh_rd_r <= !sh_rd_r;
          if (sh_rd_r) scan_r <= scan_r - 1'b1;
        end
        CMD_WRITE: wcnt_r <= wcnt_r + 1'b1;
        CMD_FIN: begin
          o_st_r <= o_st_nxt;
          o_rp_r <= o_rp_nxt;
          o_eb_r <= o_eb_nxt;
          o_ec_r <= o_ec_nxt;
          o_et_r <= o_et_nxt;
          o_ev_r <= o_ev_nxt;
          used_r <= used_nxt;
        end
        default: ;
      endcase
    end
  end

  assign out_status         = o_st_r;
  assign out_result_page    = o_rp_r;
  assign out_entry_base     = o_eb_r;
  assign out_entry_count    = o_ec_r;
  assign out_entry_type     = o_et_r;
  assign out_entry_valid    = o_ev_r;
  assign out_entries_in_use = used_r;
endmodule
`default_nettype wire

FILE: rtl/page_region_splitting_allocator_top.sv
// Top level of the page region allocator.
// Depends on pra_pkg, pra_ctrl, pra_dp and the assertion macro header.
// One request at a time. Append, read and malformed requests skip the scan; place and top scan the
// table one entry at a time, then on a match open a gap by moving each later entry up with
// a read and then a write, and write up to 3 pieces.
`default_nettype none
`include "page_region_splitting_allocator_top_assert.svh"
module page_region_splitting_allocator_top #(
  parameter int TABLE_DEPTH      = 32,
  parameter int PAGE_NUMBER_BITS = 20
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic                        cfg_index,
  input  wire logic [PAGE_NUMBER_BITS:0]   cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  in_func,
  input  wire logic [PAGE_NUMBER_BITS-1:0] in_base_page,
  input  wire logic [PAGE_NUMBER_BITS:0]   in_page_count,
  input  wire logic [3:0]                  in_mem_type,
  input  wire logic [$clog2(TABLE_DEPTH)-1:0] in_entry_index,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [1:0]                       out_status,
  output logic [PAGE_NUMBER_BITS-1:0]      out_result_page,
  output logic [PAGE_NUMBER_BITS-1:0]      out_entry_base,
  output logic [PAGE_NUMBER_BITS:0]        out_entry_count,
  output logic [3:0]                       out_entry_type,
  output logic                             out_entry_valid,
  output logic [$clog2(TABLE_DEPTH+1)-1:0] out_entries_in_use
);
  import pra_pkg::*;

  logic [PAGE_NUMBER_BITS-1:0] low_page_r;
  logic [PAGE_NUMBER_BITS:0]   high_page_r;
  pra_cmd_t  cmd;
  pra_stat_t stat;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_page_r  <= PAGE_NUMBER_BITS'(2048);
      high_page_r <= (PAGE_NUMBER_BITS+1)'(65536);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_LOW_PAGE)       low_page_r <= cfg_data[PAGE_NUMBER_BITS-1:0];
      else if (cfg_index == CFG_HIGH_PAGE) high_page_r <= cfg_data;
    end
  end

  pra_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
  );

  pra_dp #(.TABLE_DEPTH(TABLE_DEPTH), .PAGE_NUMBER_BITS(PAGE_NUMBER_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_func(in_func), .in_base_page(in_base_page), .in_page_count(in_page_count),
    .in_mem_type(in_mem_type), .in_entry_index(in_entry_index),
    .low_page(low_page_r), .high_page(high_page_r),
    .out_status(out_status), .out_result_page(out_result_page),
    .out_entry_base(out_entry_base), .out_entry_count(out_entry_count),
    .out_entry_type(out_entry_type), .out_entry_valid(out_entry_valid),
    .out_entries_in_use(out_entries_in_use)
  );

  `PRA_ASSERT_IMPL(a_used_bound, clk, rst_n, out_entries_in_use <= ($clog2(TABLE_DEPTH+1))'(TABLE_DEPTH), "table overfilled")
  `PRA_ASSERT_NEXT(a_no_accept_busy, clk, rst_n, in_valid && in_ready, !in_ready, "accepted while busy")
  `PRA_ASSERT_IMPL(a_valid_on_read, clk, rst_n, !(out_valid && out_entry_valid) || out_status == ST_OK, "valid read with error")
endmodule
`default_nettype wire

FILE: test/page_region_splitting_allocator_top_test.sv
// Self-checking testbench for page_region_splitting_allocator_top.
// Depends on pra_pkg and the allocator RTL; predicts each result from a local
// copy of the region table, or takes it from the directed row, and checks it field by field.
`default_nettype none
module page_region_splitting_allocator_top_test;
  import pra_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 32;
  localparam longint unsigned PAGE_SPAN = 64'd1 << 20;
  localparam int DRAIN_CYCLES = 200;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam int ITEMS_PER_PHASE = 190;

  typedef struct packed {
    logic [1:0]  status;
    logic [19:0] page;
    logic [19:0] ebase;
    logic [20:0] ecount;
    logic [3:0]  etype;
    logic        evalid;
    logic [5:0]  used;
  } alloc_result_t;

  typedef struct {
    logic [1:0]  func;
    logic [19:0] base;
    logic [20:0] count;
    logic [3:0]  mtype;
    logic [4:0]  idx;
    bit          typed;
    logic [1:0]  status;
    logic [5:0]  used;
  } alloc_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_valid, cfg_ready, cfg_index;
  logic [20:0] cfg_data;
  logic in_valid, in_ready;
  logic [1:0] in_func;
  logic [19:0] in_base_page;
  logic [20:0] in_page_count;
  logic [3:0] in_mem_type;
  logic [4:0] in_entry_index;
  logic out_valid, out_ready;
  logic [1:0] out_status;
  logic [19:0] out_result_page, out_entry_base;
  logic [20:0] out_entry_count;
  logic [3:0] out_entry_type;
  logic out_entry_valid;
  logic [5:0] out_entries_in_use;

  // predicted table and registers
  longint unsigned region_base_q[DEPTH];
  longint unsigned region_count_q[DEPTH];
  logic [3:0] region_type_q[DEPTH];
  int unsigned used_q;
  longint unsigned low_page_q, high_page_q;

  alloc_result_t pending_results[$];
  alloc_row_t directed_rows[$];
  int errors = 0;
  int send_idle = 0, recv_idle = 0;
  int hold_requests = 0, hold_seen = 0, hold_left = 0;
  longint cycles = 0;

  page_region_splitting_allocator_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_func(in_func),
    .in_base_page(in_base_page), .in_page_count(in_page_count),
    .in_mem_type(in_mem_type), .in_entry_index(in_entry_index),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_result_page(out_result_page), .out_entry_base(out_entry_base),
    .out_entry_count(out_entry_count), .out_entry_type(out_entry_type),
    .out_entry_valid(out_entry_valid), .out_entries_in_use(out_entries_in_use)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report(string field, longint unsigned got, longint unsigned want);
    $display("mismatch on %s: got %0d expected %0d at cycle %0d", field, got, want, cycles);
    errors++;
  endtask

  function automatic void set_region(int i, longint unsigned b, longint unsigned c,
                                     logic [3:0] t);
    region_base_q[i] = b;
    region_count_q[i] = c;
    region_type_q[i] = t;
  endfunction

  // carve [b, b+c) out of free region i, splitting off free remainders
  function automatic logic [1:0] carve_region(int i, longint unsigned b, longint unsigned c,
                                              logic [3:0] t);
    longint unsigned eb, off, tail;
    int pieces;
    eb = region_base_q[i];
    off = b - eb;
    tail = region_count_q[i] - off - c;
    if (off == 0 && tail == 0) begin
      region_type_q[i] = t;
      return ST_OK;
    end
    pieces = (off == 0 || tail == 0) ? 1 : 2;
    if (used_q + pieces > DEPTH) return ST_NOROOM;
    for (int k = int'(used_q) - 1; k > i; k--)
      set_region(k + pieces, region_base_q[k], region_count_q[k], region_type_q[k]);
    used_q += pieces;
    if (pieces == 2) begin
      set_region(i, eb, off, TYPE_FREE);
      set_region(i + 1, b, c, t);
      set_region(i + 2, b + c, tail, TYPE_FREE);
    end else if (off == 0) begin
      set_region(i, b, c, t);
      set_region(i + 1, b + c, tail, TYPE_FREE);
    end else begin
      set_region(i, eb, off, TYPE_FREE);
      set_region(i + 1, b, c, t);
    end
    return ST_OK;
  endfunction

  // apply one request to the predicted table and return its result
  function automatic alloc_result_t predict_alloc(logic [1:0] f, logic [19:0] base,
      logic [20:0] count, logic [3:0] t, logic [4:0] idx);
    alloc_result_t r;
    longint unsigned b, c, prev_end, eb, ee;
    bit bad, done;
    r = '0;
    b = 64'(base);
    c = 64'(count);
    bad = (c == 0) || (t > TYPE_MAX);
    done = 0;
    case (f)
      FUNC_APPEND: begin
        prev_end = (used_q > 0) ? region_base_q[used_q-1] + region_count_q[used_q-1] : 0;
        if (bad || b < prev_end || b + c > PAGE_SPAN) r.status = ST_INVALID;
        else if (used_q >= DEPTH) r.status = ST_NOROOM;
        else begin
          set_region(used_q, b, c, t);
          used_q++;
        end
      end
      FUNC_PLACE: begin
        if (bad) r.status = ST_INVALID;
        else begin
          r.status = ST_NOTFOUND;
          for (int i = 0; i < int'(used_q) && !done; i++) begin
            if (region_type_q[i] == TYPE_FREE && b >= region_base_q[i] &&
                b + c <= region_base_q[i] + region_count_q[i]) begin
              r.status = carve_region(i, b, c, t);
              if (r.status == ST_OK) r.page = 20'(b);
              done = 1;
            end
          end
        end
      end
      FUNC_TOP: begin
        if (bad) r.status = ST_INVALID;
        else begin
          r.status = ST_NOTFOUND;
          for (int i = 0; i < int'(used_q) && !done; i++) begin
            eb = region_base_q[i];
            ee = eb + region_count_q[i];
            if (region_type_q[i] == TYPE_FREE && !(eb < low_page_q && ee <= low_page_q)) begin
              if (eb < high_page_q && ee >= eb + c) begin
                r.status = carve_region(i, ee - c, c, t);
                if (r.status == ST_OK) r.page = 20'(ee - c);
              end
              done = 1;
            end
          end
        end
      end
      default: begin
        if (idx < used_q) begin
          r.ebase = 20'(region_base_q[idx]);
          r.ecount = 21'(region_count_q[idx]);
          r.etype = region_type_q[idx];
          r.evalid = 1'b1;
        end else r.status = ST_INVALID;
      end
    endcase
    r.used = 6'(used_q);
    return r;
  endfunction

  // offer one request, idling first at random, and record its expectation
  task automatic send_request(logic [1:0] f, logic [19:0] b, logic [20:0] c,
                              logic [3:0] t, logic [4:0] idx, bit typed,
                              logic [1:0] st, logic [5:0] used);
    alloc_result_t r;
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_base_page <= b;
    in_page_count <= c;
    in_mem_type <= t;
    in_entry_index <= idx;
    do @(posedge clk); while (!in_ready);
    r = predict_alloc(f, b, c, t, idx);
    if (typed) begin
      r = '0;
      r.status = st;
      r.used = used;
    end
    pending_results.push_back(r);
  endtask

  // write both registers once the block has drained
  task automatic write_limits(logic [20:0] low, logic [20:0] high);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_LOW_PAGE;
    cfg_data <= low;
    do @(posedge clk); while (!cfg_ready);
    low_page_q = low[19:0];
    cfg_index <= CFG_HIGH_PAGE;
    cfg_data <= high;
    do @(posedge clk); while (!cfg_ready);
    high_page_q = high;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic add_row(logic [1:0] f, logic [19:0] b, logic [20:0] c, logic [3:0] t,
                         logic [4:0] idx, bit typed, logic [1:0] st, logic [5:0] used);
    alloc_row_t row;
    row = '{f, b, c, t, idx, typed, st, used};
    directed_rows.push_back(row);
  endtask

  // one random request: mostly well-formed allocations inside free regions
  task automatic send_random();
    int pick, free_idx[$];
    longint unsigned rc, cnt, off, prev_end;
    logic [3:0] t;
    pick = $urandom_range(99);
    t = 4'($urandom_range(TYPE_MAX));
    for (int i = 0; i < int'(used_q); i++)
      if (region_type_q[i] == TYPE_FREE) free_idx.push_back(i);
    if (pick < 10) begin
      send_request(2'($urandom_range(3)), 20'($urandom), 21'($urandom),
                   4'($urandom_range(15)), 5'($urandom_range(31)), 1'b0, ST_OK, 6'd0);
    end else if (pick < 22) begin
      prev_end = (used_q > 0) ? region_base_q[used_q-1] + region_count_q[used_q-1] : 0;
      send_request(FUNC_APPEND, 20'(prev_end + $urandom_range(0, 100)),
                   21'($urandom_range(1, 4096)), $urandom_range(1) ? TYPE_FREE : t,
                   5'd0, 1'b0, ST_OK, 6'd0);
    end else if (pick < 55 && free_idx.size() != 0) begin
      pick = free_idx[$urandom_range(free_idx.size() - 1)];
      rc = region_count_q[pick];
      if ($urandom_range(7) == 0) begin
        cnt = rc;
        off = 0;
      end else begin
        cnt = $urandom_range(1, (rc < 64) ? 32'(rc) : 64);
        off = $urandom_range(0, 32'(rc - cnt));
      end
      send_request(FUNC_PLACE, 20'(region_base_q[pick] + off), 21'(cnt), t, 5'd0, 1'b0,
                   ST_OK, 6'd0);
    end else if (pick < 80) begin
      cnt = ($urandom_range(9) == 0) ? $urandom_range(1, 21'h1FFFFF) : $urandom_range(1, 64);
      send_request(FUNC_TOP, 20'($urandom), 21'(cnt), t, 5'd0, 1'b0, ST_OK, 6'd0);
    end else begin
      send_request(FUNC_READ, 20'($urandom), 21'($urandom), 4'($urandom_range(15)),
                   5'($urandom_range(31)), 1'b0, ST_OK, 6'd0);
    end
  endtask

  // result checking and receiver idling, with long holds on request
  always @(posedge clk) begin
    alloc_result_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      if (rst_n && out_valid && out_ready) begin
        if (pending_results.size() == 0) report("unexpected result", 1, 0);
        else begin
          want = pending_results.pop_front();
          if (out_status !== want.status) report("status", out_status, want.status);
          if (out_result_page !== want.page) report("result_page", out_result_page, want.page);
          if (out_entry_base !== want.ebase) report("entry_base", out_entry_base, want.ebase);
          if (out_entry_count !== want.ecount)
            report("entry_count", out_entry_count, want.ecount);
          if (out_entry_type !== want.etype) report("entry_type", out_entry_type, want.etype);
          if (out_entry_valid !== want.evalid)
            report("entry_valid", out_entry_valid, want.evalid);
          if (out_entries_in_use !== want.used)
            report("entries_in_use", out_entries_in_use, want.used);
        end
      end
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  initial begin
    rst_n <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_LOW_PAGE;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_func <= FUNC_READ;
    in_base_page <= '0;
    in_page_count <= '0;
    in_mem_type <= '0;
    in_entry_index <= '0;
    out_ready <= 1'b0;
    used_q = 0;
    low_page_q = 2048;
    high_page_q = 65536;

    // empty table, bad fields, then a four region map and every kind of split
    add_row(FUNC_READ,   0, 0, 0, 0, 1, ST_INVALID, 0);
    add_row(FUNC_APPEND, 0, 0, TYPE_FREE, 0, 1, ST_INVALID, 0);
    add_row(FUNC_APPEND, 0, 16, 4'hF, 0, 1, ST_INVALID, 0);
    add_row(FUNC_APPEND, 0, 21'h1FFFFF, TYPE_FREE, 0, 1, ST_INVALID, 0);
    add_row(FUNC_PLACE,  5, 1, TYPE_FREE, 0, 1, ST_NOTFOUND, 0);
    add_row(FUNC_TOP,    0, 1, 1, 0, 1, ST_NOTFOUND, 0);
    add_row(FUNC_APPEND, 0, 1024, TYPE_FREE, 0, 0, ST_OK, 0);
    add_row(FUNC_APPEND, 1024, 3072, 0, 0, 0, ST_OK, 0);
    add_row(FUNC_APPEND, 4096, 61440, TYPE_FREE, 0, 0, ST_OK, 0);
    add_row(FUNC_APPEND, 65536, 65536, TYPE_MAX, 0, 0, ST_OK, 0);
    add_row(FUNC_APPEND, 100, 1, TYPE_FREE, 0, 1, ST_INVALID, 4);
    add_row(FUNC_PLACE,  0, 1024, 1, 0, 0, ST_OK, 0);
    add_row(FUNC_PLACE,  4096, 16, 3, 0, 0, ST_OK, 0);
    add_row(FUNC_PLACE,  65520, 16, 4, 0, 0, ST_OK, 0);
    add_row(FUNC_PLACE,  20000, 100, 5, 0, 0, ST_OK, 0);
    add_row(FUNC_PLACE,  0, 1, 1, 0, 0, ST_OK, 0);
    add_row(FUNC_PLACE,  30000, 10, TYPE_FREE, 0, 0, ST_OK, 0);
    add_row(FUNC_TOP,    0, 64, 6, 0, 0, ST_OK, 0);
    add_row(FUNC_TOP,    0, 21'h100000, 6, 0, 0, ST_OK, 0);
    add_row(FUNC_TOP,    0, 64, 4'hF, 0, 0, ST_OK, 0);
    add_row(FUNC_APPEND, 20'hFFFFF, 1, TYPE_MAX, 0, 0, ST_OK, 0);
    add_row(FUNC_READ,   0, 0, 0, 5'd31, 0, ST_OK, 0);
    add_row(FUNC_READ,   0, 0, 0, 0, 0, ST_OK, 0);
    add_row(FUNC_READ,   0, 0, 0, 3, 0, ST_OK, 0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle = 30;
    recv_idle = 64;
    foreach (directed_rows[i])
      send_request(directed_rows[i].func, directed_rows[i].base, directed_rows[i].count,
                   directed_rows[i].mtype, directed_rows[i].idx, directed_rows[i].typed,
                   directed_rows[i].status, directed_rows[i].used);

    // random phases over register settings and idling patterns
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: write_limits(0, 21'h100000);
        1: write_limits(21'h0FFFFF, 21'h100000);
        2: write_limits(21'($urandom_range(21'h0FFFFF)), 21'($urandom_range(21'h100000)));
        3: write_limits(0, 0);
        default: write_limits(2048, 65536);
      endcase
      send_idle = (phase < 2) ? 30 : (phase < 4) ? 64 : 0;
      recv_idle = (phase < 2) ? 64 : (phase < 4) ? 30 : 0;
      if (phase == 3) hold_requests++;
      repeat (ITEMS_PER_PHASE) send_random();
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
`default_nettype wire
